[rtl/core/tlbs_pkg.sv]
// package: types, constants and codes shared by the table search block
`timescale 1ns / 1ps

package tlbs_pkg;

    localparam int TBL_DEPTH  = 16;
    localparam int TBL_IDX_W  = $clog2(TBL_DEPTH);
    localparam int TBL_BND_W  = TBL_IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int EIDX_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_LINEAR = 2'd1,
        OP_BINARY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINEAR,
        S_BINARY
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [TBL_IDX_W-1:0] pos;
        logic [DATA_W-1:0]    key;
    } t_token;

    typedef struct packed {
        logic                 en;
        logic [TBL_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
    } t_wr;

    typedef logic [TBL_DEPTH-1:0][DATA_W-1:0] t_entries;

endpackage

[rtl/core/tlbs_cell.sv]
// one table cell: holds an entry and compares it against the passing search word
`timescale 1ns / 1ps

module tlbs_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tlbs_pkg::TBL_IDX_W-1:0] i_cell_idx,
    input  tlbs_pkg::t_wr                 i_wr,
    input  tlbs_pkg::t_token              i_tok,
    output tlbs_pkg::t_token              o_tok,
    output logic [tlbs_pkg::DATA_W-1:0]   o_entry
);
    import tlbs_pkg::*;

    logic [DATA_W-1:0] r_entry;
    t_token            r_tok;
    t_token            n_tok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            r_entry <= i_wr.data;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && (r_entry == i_tok.key)) begin
            n_tok.hit = 1'b1;
            n_tok.pos = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.hit <= n_tok.hit;
        r_tok.pos <= n_tok.pos;
        r_tok.key <= n_tok.key;
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

[rtl/core/tlbs_ctrl.sv]
// controller: command decode, binary search bounds and result register
`timescale 1ns / 1ps

module tlbs_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [tlbs_pkg::OP_W-1:0]      i_operation,
    input  logic [tlbs_pkg::EIDX_W-1:0]    i_entry_index,
    input  logic [tlbs_pkg::DATA_W-1:0]    i_value,
    input  tlbs_pkg::t_entries             i_entries,
    input  tlbs_pkg::t_token               i_tail,
    output tlbs_pkg::t_token               o_head,
    output tlbs_pkg::t_wr                  o_wr,
    output logic                           busy,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [tlbs_pkg::TBL_IDX_W-1:0] o_position
);
    import tlbs_pkg::*;

    t_state                 r_state, n_state;
    logic [TBL_BND_W-1:0]   r_lo, n_lo;
    logic [TBL_BND_W-1:0]   r_hi, n_hi;
    logic [DATA_W-1:0]      r_key, n_key;
    logic                   r_valid, n_valid;
    logic                   r_found, n_found;
    logic [TBL_IDX_W-1:0]   r_pos, n_pos;

    logic                   accept;
    logic [TBL_BND_W:0]     mid_sum;
    logic [TBL_IDX_W-1:0]   mid;
    logic [DATA_W-1:0]      probe;
    logic                   bin_done;
    logic                   bin_hit;

    assign accept  = start && (r_state == S_IDLE);
    assign mid_sum = (TBL_BND_W+1)'(r_lo) + (TBL_BND_W+1)'(r_hi) - (TBL_BND_W+1)'(2);
    assign mid     = mid_sum[TBL_IDX_W:1];
    assign probe   = i_entries[mid];
    assign bin_done = r_lo > r_hi;
    assign bin_hit  = !bin_done && (probe == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_op'(i_operation) == OP_LINEAR)) begin
                    n_state = S_LINEAR;
                end else if (accept && (t_op'(i_operation) == OP_BINARY)) begin
                    n_state = S_BINARY;
                end
            end
            S_LINEAR: begin
                if (i_tail.valid) begin
                    n_state = S_IDLE;
                end
            end
            S_BINARY: begin
                if (bin_done || bin_hit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_key        = r_key;
        n_valid      = 1'b0;
        n_found      = r_found;
        n_pos        = r_pos;
        o_head       = '0;
        o_head.key   = i_value;
        o_wr.en      = 1'b0;
        o_wr.idx     = TBL_IDX_W'(i_entry_index);
        o_wr.data    = i_value;
        unique case (r_state)
            S_IDLE: begin
                o_head.valid = accept && (t_op'(i_operation) == OP_LINEAR);
                o_wr.en      = accept && (t_op'(i_operation) == OP_WRITE)
                               && (32'(i_entry_index) < TBL_DEPTH);
                n_lo         = TBL_BND_W'(1);
                n_hi         = TBL_BND_W'(TBL_DEPTH);
                n_key        = i_value;
            end
            S_LINEAR: begin
                if (i_tail.valid) begin
                    n_valid = 1'b1;
                    n_found = i_tail.hit;
                    n_pos   = i_tail.hit ? i_tail.pos : '0;
                end
            end
            S_BINARY: begin
                if (bin_done) begin
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_pos   = '0;
                end else if (bin_hit) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_pos   = mid;
                end else if ($signed(probe) < $signed(r_key)) begin
                    n_lo = TBL_BND_W'(mid) + TBL_BND_W'(2);
                end else begin
                    n_hi = TBL_BND_W'(mid);
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

[rtl/core/table_linear_binary_search.sv]
// top level: searchable table built as a row of compare cells plus controller
//
// channel   direction  handshake          fields
// command   in         start, busy        i_operation, i_entry_index, i_value
// result    out        o_valid (strobe)   o_found, o_position
//
// a word is taken when start is high and busy is low; writes finish in that cycle
// linear search: the key walks the cell row one cell per cycle and passes every cell
// register before the result register; binary search: one probe per cycle plus an
// empty-range check on a miss, then the result register
// busy is high until the result strobe; o_valid is high for one cycle and cannot
// be stalled; synchronous active-low reset
`timescale 1ns / 1ps

module table_linear_binary_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [tlbs_pkg::OP_W-1:0]      i_operation,
    input  logic [tlbs_pkg::EIDX_W-1:0]    i_entry_index,
    input  logic [tlbs_pkg::DATA_W-1:0]    i_value,
    output logic                           busy,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [tlbs_pkg::TBL_IDX_W-1:0] o_position
);
    import tlbs_pkg::*;

    t_token   chain [TBL_DEPTH+1];
    t_entries entries;
    t_wr      wr;

    tlbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_value       (i_value),
        .i_entries     (entries),
        .i_tail        (chain[TBL_DEPTH]),
        .o_head        (chain[0]),
        .o_wr          (wr),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_cell
        tlbs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (TBL_IDX_W'(g)),
            .i_wr       (wr),
            .i_tok      (chain[g]),
            .o_tok      (chain[g+1]),
            .o_entry    (entries[g])
        );
    end

endmodule
